### design/semaphore_blocked_queue_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the semaphore blocked-queue table
// Each macro takes a label, a clock, a reset condition and an expression.
// ----------------------------------------------------------------------------
`ifndef SEMAPHORE_BLOCKED_QUEUE_TABLE_MACROS_SVH
`define SEMAPHORE_BLOCKED_QUEUE_TABLE_MACROS_SVH
`ifndef SYNTH
`define SBQT_ASSERT_IMPL(label, clk, rst, prop) \
    label: assert property (@(posedge clk) disable iff (rst) prop) \
        else $error("assertion failed");
`define SBQT_ASSERT_NEVER(label, clk, rst, expr) \
    label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
        else $error("forbidden condition");
`else
`define SBQT_ASSERT_IMPL(label, clk, rst, prop)
`define SBQT_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

### design/sbqt_pkg.sv
// ----------------------------------------------------------------------------
// Semaphore blocked-queue table package
// Payload types, operation and status codes, and the controller command set.
// ----------------------------------------------------------------------------
`default_nettype none
package sbqt_pkg;
    localparam logic [2:0] OP_BLOCK   = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_UNBLOCK = 3'd2;
    localparam logic [2:0] OP_PEEK    = 3'd3;
    localparam logic [2:0] OP_FIND    = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] sem_key;
        logic [4:0]  proc;
        logic [30:0] pid;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] proc_out;
    } out_word_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // capture input word, start scan
        logic scan;     // examine next group of entries of the scan
        logic execute;  // apply the operation once the scan is done
    } ctl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;
    } dp_stat_t;
endpackage
`default_nettype wire

### design/sbqt_ctrl.sv
// ----------------------------------------------------------------------------
// Semaphore blocked-queue table controller
// Sequences load, scan and execute, and holds the result register handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module sbqt_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sbqt_pkg::ctl_cmd_t     cmd,
    input  wire sbqt_pkg::dp_stat_t stat
);
    import sbqt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

### design/sbqt_dp.sv
// ----------------------------------------------------------------------------
// Semaphore blocked-queue table datapath
// Descriptor and process tables, a banked scan over them and the list update.
// ----------------------------------------------------------------------------
`default_nettype none
module sbqt_dp #(
    parameter int MAX_PROCS = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sbqt_pkg::in_word_t  in_word,
    input  wire sbqt_pkg::ctl_cmd_t  cmd,
    output sbqt_pkg::dp_stat_t       stat,
    output sbqt_pkg::out_word_t      out_word
);
    import sbqt_pkg::*;

    localparam int IW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int BANK  = 8;
    localparam int NGRP  = (MAX_PROCS + BANK - 1) / BANK;
    localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int CW    = $clog2(MAX_PROCS + 1);

    logic [MAX_PROCS-1:0] sem_in_use_reg;
    logic [31:0]          key_tab   [MAX_PROCS];
    logic [IW-1:0]        head_tab  [MAX_PROCS];
    logic [IW-1:0]        tail_tab  [MAX_PROCS];
    logic [CW-1:0]        count_reg [MAX_PROCS];
    logic [IW-1:0]        next_tab  [MAX_PROCS];
    logic [IW-1:0]        prev_tab  [MAX_PROCS];
    logic [MAX_PROCS-1:0] blocked_reg;
    logic [IW-1:0]        slot_tab  [MAX_PROCS];
    logic [30:0]          pid_tab   [MAX_PROCS];

    in_word_t      req_reg;
    out_word_t     res_reg;
    logic [GW-1:0] grp_reg;
    // Scan results: matching key, first free descriptor, first pid match.
    logic          key_hit_reg, free_hit_reg, pid_hit_reg;
    logic [IW-1:0] key_idx_reg, free_idx_reg, pid_idx_reg;

    assign out_word       = res_reg;
    assign stat.scan_done = (grp_reg == GW'(NGRP - 1));

    // One group of up to eight entries is examined per scan cycle.
    logic          g_key_hit, g_free_hit, g_pid_hit;
    logic [IW-1:0] g_key_idx, g_free_idx, g_pid_idx;
    always_comb begin
        int e;
        g_key_hit = 1'b0; g_free_hit = 1'b0; g_pid_hit = 1'b0;
        g_key_idx = '0;   g_free_idx = '0;   g_pid_idx = '0;
        for (int b = BANK - 1; b >= 0; b--) begin
            e = int'(grp_reg) * BANK + b;
            if (e < MAX_PROCS) begin
                if (sem_in_use_reg[e] && key_tab[e] == req_reg.sem_key) begin
                    g_key_hit = 1'b1; g_key_idx = IW'(e);
                end
                if (!sem_in_use_reg[e]) begin
                    g_free_hit = 1'b1; g_free_idx = IW'(e);
                end
                if (blocked_reg[e] && pid_tab[e] == req_reg.pid) begin
                    g_pid_hit = 1'b1; g_pid_idx = IW'(e);
                end
            end
        end
    end

    // Decision for the execute step.
    logic          p_ok;
    logic [IW-1:0] p_idx;
    assign p_ok  = ({27'd0, req_reg.proc} < 32'(MAX_PROCS));
    assign p_idx = IW'(req_reg.proc);

    logic          do_link, do_unlink, new_desc;
    logic [IW-1:0] s_sel, u_p, u_s, u_nx, u_pv;
    logic [1:0]    st;
    logic [4:0]    res_p;
    always_comb begin
        do_link = 1'b0; do_unlink = 1'b0; new_desc = 1'b0;
        s_sel = key_idx_reg; u_p = p_idx;
        st = ST_NONE; res_p = '0;
        case (req_reg.op)
            OP_BLOCK: begin
                if (p_ok && !blocked_reg[p_idx]) begin
                    if (key_hit_reg) begin
                        do_link = 1'b1; st = ST_OK;
                    end else if (free_hit_reg) begin
                        do_link = 1'b1; new_desc = 1'b1;
                        s_sel = free_idx_reg; st = ST_OK;
                    end else begin
                        st = ST_FULL;
                    end
                end
            end
            OP_RELEASE, OP_PEEK: begin
                if (key_hit_reg && count_reg[key_idx_reg] != '0) begin
                    u_p = head_tab[key_idx_reg];
                    do_unlink = (req_reg.op == OP_RELEASE);
                    st = ST_OK; res_p = 5'(head_tab[key_idx_reg]);
                end
            end
            OP_UNBLOCK: begin
                if (p_ok && blocked_reg[p_idx]) begin
                    do_unlink = 1'b1; st = ST_OK; res_p = req_reg.proc;
                end
            end
            OP_FIND: begin
                if (pid_hit_reg) begin
                    st = ST_OK; res_p = 5'(pid_idx_reg);
                end
            end
            default: st = ST_NONE;
        endcase
        u_s  = slot_tab[u_p];
        u_nx = next_tab[u_p];
        u_pv = prev_tab[u_p];
    end

    logic link_empty;
    assign link_empty = new_desc || (count_reg[s_sel] == '0);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= in_word;
        end
        if (cmd.execute) begin
            res_reg <= '{status: st, proc_out: res_p};
        end
        if (do_link && cmd.execute) begin
            if (new_desc) key_tab[s_sel] <= req_reg.sem_key;
            if (link_empty) begin
                head_tab[s_sel] <= p_idx;
            end else begin
                next_tab[tail_tab[s_sel]] <= p_idx;
                prev_tab[p_idx] <= tail_tab[s_sel];
            end
            tail_tab[s_sel]  <= p_idx;
            slot_tab[p_idx]  <= s_sel;
            pid_tab[p_idx]   <= req_reg.pid;
        end
        if (do_unlink && cmd.execute) begin
            if (head_tab[u_s] == u_p) head_tab[u_s] <= u_nx;
            else next_tab[u_pv] <= u_nx;
            if (tail_tab[u_s] == u_p) tail_tab[u_s] <= u_pv;
            else prev_tab[u_nx] <= u_pv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sem_in_use_reg <= '0;
            blocked_reg    <= '0;
            grp_reg        <= '0;
            key_hit_reg    <= 1'b0;
            free_hit_reg   <= 1'b0;
            pid_hit_reg    <= 1'b0;
            for (int i = 0; i < MAX_PROCS; i++) count_reg[i] <= '0;
        end else begin
            if (cmd.load) begin
                grp_reg      <= '0;
                key_hit_reg  <= 1'b0;
                free_hit_reg <= 1'b0;
                pid_hit_reg  <= 1'b0;
            end else if (cmd.scan) begin
                if (!stat.scan_done) grp_reg <= grp_reg + GW'(1);
                if (!key_hit_reg && g_key_hit) begin
                    key_hit_reg <= 1'b1; key_idx_reg <= g_key_idx;
                end
                if (!free_hit_reg && g_free_hit) begin
                    free_hit_reg <= 1'b1; free_idx_reg <= g_free_idx;
                end
                if (!pid_hit_reg && g_pid_hit) begin
                    pid_hit_reg <= 1'b1; pid_idx_reg <= g_pid_idx;
                end
            end
            if (cmd.execute && do_link) begin
                sem_in_use_reg[s_sel] <= 1'b1;
                count_reg[s_sel] <= (new_desc ? '0 : count_reg[s_sel]) + CW'(1);
                blocked_reg[p_idx] <= 1'b1;
            end
            if (cmd.execute && do_unlink) begin
                count_reg[u_s] <= count_reg[u_s] - CW'(1);
                if (count_reg[u_s] == CW'(1)) sem_in_use_reg[u_s] <= 1'b0;
                blocked_reg[u_p] <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

### design/semaphore_blocked_queue_table.sv
// ----------------------------------------------------------------------------
// Semaphore blocked-queue table
// Pool of semaphore descriptors, each holding a FIFO of blocked processes.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. An accepted word is loaded in its
// accepting cycle, then the tables are scanned eight entries a cycle (key
// lookup, free descriptor and pid search together) and the linked lists are
// updated. The result then stands in the output register until taken, and
// the block is ready again the cycle after; it takes no new word while a
// result waits.
`default_nettype none
`include "semaphore_blocked_queue_table_macros.svh"
module semaphore_blocked_queue_table #(
    parameter int MAX_PROCS = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire sbqt_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output sbqt_pkg::out_word_t      m_data
);
    import sbqt_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    sbqt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    sbqt_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_word  (s_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_word (m_data)
    );

    `SBQT_ASSERT_NEVER(a_no_overlap, aclk, !aresetn, s_ready && m_valid)
    `SBQT_ASSERT_IMPL(a_accept_scans, aclk, !aresetn, (s_valid && s_ready) |=> cmd.scan)
    `SBQT_ASSERT_IMPL(a_exec_result, aclk, !aresetn, cmd.execute |=> m_valid)
    `SBQT_ASSERT_IMPL(a_status_range, aclk, !aresetn, m_valid |-> (m_data.status != 2'd3))
endmodule
`default_nettype wire
